### hw/rtl/com_pkg.sv
package com_pkg;

  localparam int PHASES      = 6;
  localparam int VOICES      = 6;
  localparam int MIN_VOICES  = 4;

  localparam int PHASE_W     = 32;
  localparam int PW_W        = 16;
  localparam int SAMPLE_W    = 16;
  localparam int VAL_W       = 18;
  localparam int WAVE_W      = 2;
  localparam int COUNT_W     = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_VOICE_COUNT = 3'd7;

  localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;

  localparam int SQUARE_LEVEL = 5400;
  localparam int TRI_OFFSET   = 16384;
  localparam int HALF_SCALE   = 32768;
  localparam int SAMPLE_MAX   = 32767;
  localparam int SAMPLE_MIN   = -32768;

  typedef struct packed {
    logic [WAVE_W-1:0]  waveform;
    logic [COUNT_W-1:0] voice_count;
  } mix_cfg_t;

endpackage

### hw/rtl/com_phase_bank.sv
module com_phase_bank (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [com_pkg::PHASE_W-1:0]  increment [com_pkg::PHASES],
  output logic [com_pkg::PHASE_W-1:0]  phase     [com_pkg::PHASES]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < com_pkg::PHASES; i++) begin
        phase[i] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < com_pkg::PHASES; i++) begin
        phase[i] <= phase[i] + increment[i];
      end
    end
  end

endmodule

### hw/rtl/com_mix.sv
module com_mix #(
  parameter int VOICES = com_pkg::VOICES
) (
  input  com_pkg::mix_cfg_t                   cfg,
  input  logic [com_pkg::PW_W-1:0]            pulse_width,
  input  logic [com_pkg::PHASE_W-1:0]         phase [VOICES],
  output logic signed [com_pkg::SAMPLE_W-1:0] sample
);

  localparam int VAL_W   = com_pkg::VAL_W;
  localparam int SUM_W   = $clog2(VOICES * com_pkg::HALF_SCALE + 1) + 1;
  localparam int COUNT_W = com_pkg::COUNT_W;

  logic signed [VAL_W-1:0]   val [VOICES];
  logic [COUNT_W-1:0]        count;
  logic [com_pkg::PHASE_W-1:0] threshold;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   scaled;

  assign threshold = {pulse_width, {(com_pkg::PHASE_W - com_pkg::PW_W){1'b0}}};

  always_comb begin
    count = cfg.voice_count;
    if (count < COUNT_W'(com_pkg::MIN_VOICES)) begin
      count = COUNT_W'(com_pkg::MIN_VOICES);
    end
    if (count > COUNT_W'(VOICES)) begin
      count = COUNT_W'(VOICES);
    end
  end

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      case (cfg.waveform)
        com_pkg::WAVE_SAW: begin
          val[i] = VAL_W'(com_pkg::HALF_SCALE) - $signed({2'b00, phase[i][31:16]});
        end
        com_pkg::WAVE_TRIANGLE: begin
          if (phase[i][com_pkg::PHASE_W-1]) begin
            val[i] = VAL_W'(com_pkg::TRI_OFFSET + com_pkg::HALF_SCALE)
                     - $signed({2'b00, phase[i][31:16]});
          end else begin
            val[i] = $signed({2'b00, phase[i][31:16]})
                     - VAL_W'(com_pkg::HALF_SCALE - com_pkg::TRI_OFFSET);
          end
        end
        default: begin
          val[i] = (phase[i] > threshold) ? VAL_W'(com_pkg::SQUARE_LEVEL)
                                          : VAL_W'(-com_pkg::SQUARE_LEVEL);
        end
      endcase
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (COUNT_W'(i) < count) begin
        sum = sum + SUM_W'(val[i]);
      end
    end
  end

  always_comb begin
    case (cfg.waveform)
      com_pkg::WAVE_SAW:      scaled = (sum >>> 2) + (sum >>> 5);
      com_pkg::WAVE_TRIANGLE: scaled = (sum >>> 2) + (sum >>> 3);
      default:                scaled = sum;
    endcase
  end

  always_comb begin
    if (scaled > SUM_W'(com_pkg::SAMPLE_MAX)) begin
      sample = com_pkg::SAMPLE_W'(com_pkg::SAMPLE_MAX);
    end else if (scaled < SUM_W'(com_pkg::SAMPLE_MIN)) begin
      sample = com_pkg::SAMPLE_W'(com_pkg::SAMPLE_MIN);
    end else begin
      sample = scaled[com_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

### hw/rtl/chord_oscillator_mixer_core.sv
// Six-voice phase accumulator oscillator with mixer. Each tick transaction
// advances all six 32-bit phases by their increments; the first voice_count
// voices (clamped to 4..VOICES) are shaped as saw, triangle or square (code 3
// acts as square), summed, scaled and clipped to one signed 16-bit sample.
// The block takes one tick per cycle while tick_stall is low. The accepting
// edge loads the phase accumulators and the pulse width register; when the
// stage moves on, the mixed sample goes into the output register and
// sample_valid rises. tick_stall follows sample_stall in the same cycle when
// both stages are full. Configuration writes are meant for idle periods only.
module chord_oscillator_mixer_core #(
  parameter int VOICES = com_pkg::VOICES
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_write,
  input  logic [com_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [com_pkg::CFG_DATA_W-1:0]      cfg_data,

  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  logic [com_pkg::PW_W-1:0]            pulse_width,

  output logic                                sample_valid,
  input  logic                                sample_stall,
  output logic signed [com_pkg::SAMPLE_W-1:0] sample_out
);

  logic [com_pkg::PHASE_W-1:0] increment [com_pkg::PHASES];
  logic [com_pkg::PHASE_W-1:0] phase     [com_pkg::PHASES];
  com_pkg::mix_cfg_t           mix_cfg;

  logic                        stage_valid;
  logic [com_pkg::PW_W-1:0]    stage_pw;
  logic                        stage_move;
  logic                        accept;
  logic signed [com_pkg::SAMPLE_W-1:0] mixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < com_pkg::PHASES; i++) begin
        increment[i] <= '0;
      end
      mix_cfg.waveform    <= com_pkg::WAVE_SAW;
      mix_cfg.voice_count <= com_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      if (cfg_index < com_pkg::CFG_INDEX_W'(com_pkg::PHASES)) begin
        increment[cfg_index] <= cfg_data;
      end else if (cfg_index == com_pkg::REG_WAVEFORM) begin
        mix_cfg.waveform <= cfg_data[com_pkg::WAVE_W-1:0];
      end else if (cfg_index == com_pkg::REG_VOICE_COUNT) begin
        mix_cfg.voice_count <= cfg_data[com_pkg::COUNT_W-1:0];
      end
    end
  end

  assign stage_move = stage_valid && (!sample_valid || !sample_stall);
  assign tick_stall = stage_valid && !stage_move;
  assign accept     = tick_valid && !tick_stall;

  com_phase_bank u_phase_bank (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .increment (increment),
    .phase     (phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_pw <= pulse_width;
    end
  end

  com_mix #(
    .VOICES (VOICES)
  ) u_mix (
    .cfg         (mix_cfg),
    .pulse_width (stage_pw),
    .phase       (phase[0:VOICES-1]),
    .sample      (mixed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (stage_move) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      sample_out <= mixed;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 200;
  localparam int MAX_GAP        = 13;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 125;
  localparam int HOLD_PHASE     = 3;
  localparam int REPORT_LIMIT   = 10;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [com_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [com_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                tick_valid = 1'b0;
  logic                                tick_stall;
  logic [com_pkg::PW_W-1:0]            pulse_width = '0;
  logic                                sample_valid;
  logic                                sample_stall = 1'b0;
  logic signed [com_pkg::SAMPLE_W-1:0] sample_out;

  chord_oscillator_mixer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .pulse_width  (pulse_width),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_out   (sample_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // oscillator state as the block should hold it
  logic [com_pkg::PHASE_W-1:0] osc_phase [com_pkg::PHASES];
  logic [com_pkg::PHASE_W-1:0] osc_incr [com_pkg::PHASES];
  logic [com_pkg::WAVE_W-1:0]  osc_wave;
  logic [com_pkg::COUNT_W-1:0] osc_count;
  logic [com_pkg::PHASE_W-1:0] next_incr [com_pkg::PHASES];

  logic [com_pkg::PW_W-1:0]            tick_backlog [$];
  logic signed [com_pkg::SAMPLE_W-1:0] pending_samples [$];

  int  ticks_sent = 0;
  int  ticks_taken = 0;
  int  samples_done = 0;
  int  mismatches = 0;
  int  tick_gap = 0;
  int  rx_wait = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  tx_gaps_on = 1'b0;
  bit  rx_gaps_on = 1'b0;
  logic hold_start = 1'b0;

  function automatic logic signed [com_pkg::SAMPLE_W-1:0] mix_next_sample(
    input logic [com_pkg::PW_W-1:0] pw
  );
    int count;
    int sum;
    int h;
    int v;
    logic [com_pkg::PHASE_W-1:0] threshold;
    threshold = {pw, 16'h0000};
    count = int'(osc_count);
    if (count < com_pkg::MIN_VOICES) count = com_pkg::MIN_VOICES;
    if (count > com_pkg::VOICES) count = com_pkg::VOICES;
    for (int i = 0; i < com_pkg::PHASES; i++) osc_phase[i] = osc_phase[i] + osc_incr[i];
    sum = 0;
    for (int i = 0; i < count; i++) begin
      h = int'(osc_phase[i][com_pkg::PHASE_W-1:16]);
      case (osc_wave)
        com_pkg::WAVE_SAW: v = com_pkg::HALF_SCALE - h;
        com_pkg::WAVE_TRIANGLE: v = osc_phase[i][com_pkg::PHASE_W-1]
                                    ? com_pkg::TRI_OFFSET + com_pkg::HALF_SCALE - h
                                    : com_pkg::TRI_OFFSET + h - com_pkg::HALF_SCALE;
        default: v = (osc_phase[i] > threshold) ? com_pkg::SQUARE_LEVEL
                                                : -com_pkg::SQUARE_LEVEL;
      endcase
      sum += v;
    end
    if (osc_wave == com_pkg::WAVE_SAW) sum = (sum >>> 2) + (sum >>> 5);
    else if (osc_wave == com_pkg::WAVE_TRIANGLE) sum = (sum >>> 2) + (sum >>> 3);
    if (sum > com_pkg::SAMPLE_MAX) sum = com_pkg::SAMPLE_MAX;
    if (sum < com_pkg::SAMPLE_MIN) sum = com_pkg::SAMPLE_MIN;
    return sum[com_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic [com_pkg::PHASE_W-1:0] draw_increment();
    case ($urandom_range(0, 5))
      0: return com_pkg::PHASE_W'($urandom_range(0, 65535));
      1: return 32'hFFFF_FFFF - com_pkg::PHASE_W'($urandom_range(0, 65535));
      2: return 32'h8000_0000 + com_pkg::PHASE_W'($urandom_range(0, 1 << 20));
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [com_pkg::PW_W-1:0] draw_pulse_width();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000 ^ com_pkg::PW_W'($urandom_range(0, 255));
      default: return com_pkg::PW_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [com_pkg::CFG_INDEX_W-1:0] index,
                           input logic [com_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    case (index)
      com_pkg::REG_WAVEFORM:    osc_wave = data[com_pkg::WAVE_W-1:0];
      com_pkg::REG_VOICE_COUNT: osc_count = data[com_pkg::COUNT_W-1:0];
      default:                  osc_incr[index] = data;
    endcase
  endtask

  task automatic apply_config(input logic [com_pkg::CFG_DATA_W-1:0] wave_data,
                              input logic [com_pkg::CFG_DATA_W-1:0] count_data);
    for (int i = 0; i < com_pkg::PHASES; i++) begin
      write_reg(com_pkg::CFG_INDEX_W'(i), next_incr[i]);
    end
    write_reg(com_pkg::REG_WAVEFORM, wave_data);
    write_reg(com_pkg::REG_VOICE_COUNT, count_data);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_tick(input logic [com_pkg::PW_W-1:0] pw);
    tick_backlog.push_back(pw);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    while (ticks_taken != ticks_sent || samples_done != ticks_taken) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : tick_driver
    int gap;
    gap = tick_gap;
    if (rst) begin
      tick_valid  <= 1'b0;
      tick_gap    <= 0;
      ticks_taken <= 0;
    end else if (!(tick_valid && tick_stall)) begin
      if (tick_valid) begin
        pending_samples.push_back(mix_next_sample(pulse_width));
        ticks_taken <= ticks_taken + 1;
      end
      if (gap != 0) begin
        tick_valid <= 1'b0;
        tick_gap   <= gap - 1;
      end else if (tick_backlog.size() != 0) begin
        tick_valid  <= 1'b1;
        pulse_width <= tick_backlog.pop_front();
        tick_gap    <= tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : sample_monitor
    int wait_left;
    int hl;
    logic stall_next;
    logic signed [com_pkg::SAMPLE_W-1:0] want;
    wait_left = rx_wait;
    hl = hold_left;
    if (rst) begin
      sample_stall <= 1'b0;
      rx_wait      <= 0;
      hold_left    <= 0;
      samples_done <= 0;
    end else begin
      if (sample_valid && !sample_stall) begin
        samples_done <= samples_done + 1;
        if (pending_samples.size() == 0) begin
          if (mismatches < REPORT_LIMIT) $display("unexpected sample %0d", sample_out);
          mismatches++;
        end else begin
          want = pending_samples.pop_front();
          if (sample_out !== want) begin
            if (mismatches < REPORT_LIMIT)
              $display("sample %0d: expected %0d, got %0d", samples_done, want, sample_out);
            mismatches++;
          end
        end
        wait_left = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_start) hl = HOLD_CYCLES;
      if (hl != 0) begin
        stall_next = 1'b1;
        hl--;
      end else if (wait_left != 0) begin
        stall_next = 1'b1;
        wait_left--;
      end else begin
        stall_next = 1'b0;
      end
      sample_stall <= stall_next;
      rx_wait      <= wait_left;
      hold_left    <= hl;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (tick_valid && !tick_stall) || (sample_valid && !sample_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles < WATCHDOG_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [com_pkg::CFG_DATA_W-1:0] wave_data;
    logic [com_pkg::CFG_DATA_W-1:0] count_data;
    for (int i = 0; i < com_pkg::PHASES; i++) begin
      osc_phase[i] = '0;
      osc_incr[i]  = '0;
    end
    osc_wave  = com_pkg::WAVE_SAW;
    osc_count = com_pkg::COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero phases, saw, saturates high
    queue_tick('0);
    queue_tick('1);
    queue_tick(16'h1234);
    wait_idle();

    // all increments at maximum, six voices, saturates low
    for (int i = 0; i < com_pkg::PHASES; i++) next_incr[i] = '1;
    apply_config(com_pkg::CFG_DATA_W'(com_pkg::WAVE_SAW), 6);
    queue_tick('0);
    queue_tick('1);
    queue_tick(16'h8000);
    wait_idle();

    // triangle around the fold
    for (int i = 0; i < com_pkg::PHASES; i++) begin
      next_incr[i] = (i < 3) ? 32'h8000_0000 : 32'h4000_0000;
    end
    apply_config(com_pkg::CFG_DATA_W'(com_pkg::WAVE_TRIANGLE), 5);
    repeat (4) queue_tick(draw_pulse_width());
    wait_idle();

    // code three acts as square, count above the voice limit
    for (int i = 0; i < com_pkg::PHASES; i++) next_incr[i] = $urandom;
    apply_config('1, '1);
    queue_tick('0);
    queue_tick('1);
    queue_tick(16'h7FFF);
    queue_tick(16'h8000);
    wait_idle();

    // square, count below four
    for (int i = 0; i < com_pkg::PHASES; i++) next_incr[i] = 32'h0001_0000 * (i + 1);
    apply_config(com_pkg::CFG_DATA_W'(com_pkg::WAVE_SQUARE), 0);
    queue_tick('0);
    queue_tick(16'h0001);
    queue_tick(16'h0003);
    queue_tick('1);
    wait_idle();

    // triangle near zero phase, count three
    for (int i = 0; i < com_pkg::PHASES; i++) next_incr[i] = i + 1;
    apply_config(com_pkg::CFG_DATA_W'(com_pkg::WAVE_TRIANGLE), 3);
    repeat (3) queue_tick(draw_pulse_width());
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < com_pkg::PHASES; i++) next_incr[i] = draw_increment();
      wave_data  = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      wave_data[com_pkg::WAVE_W-1:0] = com_pkg::WAVE_W'($urandom_range(0, 3));
      count_data = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      count_data[com_pkg::COUNT_W-1:0] = ($urandom_range(0, 4) == 0)
                                         ? com_pkg::COUNT_W'($urandom_range(0, 7))
                                         : com_pkg::COUNT_W'($urandom_range(4, 6));
      tx_gaps_on = (p == HOLD_PHASE) ? 1'b0 : ($urandom_range(0, 2) != 0);
      rx_gaps_on = $urandom_range(0, 2) != 0;
      apply_config(wave_data, count_data);
      for (int n = 0; n < PHASE_ITEMS; n++) queue_tick(draw_pulse_width());
      if (p == HOLD_PHASE) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
